// File: src/ftmq_pkg.sv
// Shared constants for the framed token message queue.
// Operation codes, configuration register indexes and default sizes.
`timescale 1ns / 1ps

package ftmq_pkg;

  localparam int unsigned RingBytesDef  = 64;
  localparam int unsigned TokenSlotsDef = 32;
  localparam int unsigned MsgSlotsDef   = 8;
  localparam int unsigned CopyLenDef    = 20;

  typedef enum logic [1:0] {
    OP_RX_CHAR  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_READ_TOK = 2'd2,
    OP_CLR_CNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_DELIM = 2'd1,
    CFG_STOP  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] StartCharRst = 8'd91;
  localparam logic [7:0] DelimCharRst = 8'd44;
  localparam logic [7:0] StopCharRst  = 8'd93;

endpackage

// File: src/ftmq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ftmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/framed_token_message_queue_top.sv
// Framed token message queue: top level with the receive/release/read sequencer.
// Depends on ftmq_pkg and ftmq_ram (byte ring, token start ring, message table).
`timescale 1ns / 1ps

// Characters framed by start/delimiter/stop are split into zero-terminated
// tokens held in a byte ring, with a ring of token start offsets and a table of
// message records, all in synchronous RAMs. One transaction is taken at a time.
// Each transaction steps through the sequencer states: a received character
// goes through EXEC and REC (or FILL and FILL2 when it commits a message, to
// reload the record of the next table slot) to OUT; release passes REL and
// clear-count CLR before REC and OUT; a token read passes T1 and T2, then
// loops B and DRAIN once per returned byte (up to CopyLen bytes), since the
// table, token and byte RAMs have registered read data. The input is taken
// again once the last result has been taken and the sequencer is back in idle.
// Each result waits in an output register for as long as out_stall_i holds it.

module framed_token_message_queue_top
  import ftmq_pkg::*;
#(
  parameter int unsigned RingBytes  = RingBytesDef,
  parameter int unsigned TokenSlots = TokenSlotsDef,
  parameter int unsigned MsgSlots   = MsgSlotsDef,
  parameter int unsigned CopyLen    = CopyLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_char_i,
  input  logic [4:0] token_number_i,
  input  logic       consumer_ready_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic       msg_complete_o,
  output logic [3:0] msg_count_o,
  output logic [5:0] oldest_token_count_o,
  output logic [6:0] free_bytes_o,
  output logic [7:0] token_byte_o,
  output logic       last_o
);

  localparam int unsigned RW   = $clog2(RingBytes);
  localparam int unsigned RCW  = $clog2(RingBytes + 1);
  localparam int unsigned TW   = $clog2(TokenSlots);
  localparam int unsigned TCW  = $clog2(TokenSlots + 1);
  localparam int unsigned MW   = (MsgSlots > 1) ? $clog2(MsgSlots) : 1;
  localparam int unsigned MCW  = $clog2(MsgSlots + 1);
  localparam int unsigned RECW = TW + TCW + RCW;
  localparam int unsigned NW   = $clog2(CopyLen);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_REL, S_CLR, S_T1, S_T2, S_B,
    S_FILL, S_FILL2, S_REC, S_OUT, S_DRAIN
  } state_e;

  state_e state_q;

  // configuration
  logic [7:0] start_q, delim_q, stop_q;

  // latched transaction
  logic [1:0] op_q;
  logic [7:0] chr_q;
  logic [4:0] tn_q;
  logic       rdy_q;

  // queue state
  logic           rcv_q;
  logic [RW-1:0]  rwi_q;
  logic [RCW-1:0] rused_q;
  logic [TW-1:0]  twi_q;
  logic [TCW-1:0] tused_q, cur_q;
  logic [MW-1:0]  wi_q, ri_q;
  logic [MCW-1:0] held_q;
  logic [TCW-1:0] bk_tused_q;
  logic [RW-1:0]  bk_rwi_q;
  logic [RCW-1:0] bk_rused_q;

  // copy of the table record at the write slot
  logic [TW-1:0]  recf_q;
  logic [TCW-1:0] recc_q;
  logic [RCW-1:0] recb_q;

  // token read run
  logic [RW-1:0]  p_q;
  logic [NW-1:0]  run_q;
  logic [TCW-1:0] oldest_q;

  // output register
  logic       ovalid_q, acc_q, done_q, last_q;
  logic [3:0] cnt_q;
  logic [5:0] old_q;
  logic [6:0] free_q;
  logic [7:0] byte_q;

  // RAM ports
  logic            b_we;
  logic [RW-1:0]   b_waddr, b_raddr;
  logic [7:0]      b_wdata, b_rdata;
  logic            t_we;
  logic [TW-1:0]   t_waddr, t_raddr;
  logic [RW-1:0]   t_wdata, t_rdata;
  logic            m_we;
  logic [MW-1:0]   m_waddr, m_raddr;
  logic [RECW-1:0] m_wdata, m_rdata;

  // character step results
  logic           rcv_n, acc_n, done_n, commit_n, rb_n;
  logic [RW-1:0]  rwi_n;
  logic [RCW-1:0] rused_n;
  logic [TW-1:0]  twi_n;
  logic [TCW-1:0] tused_n, cur_n;
  logic [MW-1:0]  wi_n;
  logic [MCW-1:0] held_n;
  logic [TCW-1:0] recc_n;
  logic [RCW-1:0] recb_n;
  logic [TW-1:0]  recf_n;
  logic           bwe_n, twe_n;
  logic [RW-1:0]  twdata_n;
  logic [TW-1:0]  twaddr_n;
  logic [7:0]     bwdata_n;

  // misc
  logic [TW-1:0]  tn_mod [32];
  logic [TW:0]    slot_sum;
  logic [TW-1:0]  slot;
  logic [TCW-1:0] rd_cnt;
  logic [RCW-1:0] rd_bytes;
  logic [RW-1:0]  p_next;
  logic [6:0]     free_now;
  logic           in_acc, out_take, run_end;

  for (genvar i = 0; i < 32; i++) begin : g_tn_mod
    assign tn_mod[i] = TW'(i % TokenSlots);
  end

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] x);
    return (x == RW'(RingBytes - 1)) ? '0 : x + RW'(1);
  endfunction

  function automatic logic [TW-1:0] tok_inc(input logic [TW-1:0] x);
    return (x == TW'(TokenSlots - 1)) ? '0 : x + TW'(1);
  endfunction

  function automatic logic [MW-1:0] msg_inc(input logic [MW-1:0] x);
    return (x == MW'(MsgSlots - 1)) ? '0 : x + MW'(1);
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = ovalid_q && !out_stall_i;

  assign rd_cnt   = m_rdata[RCW +: TCW];
  assign rd_bytes = m_rdata[RCW-1:0];
  assign slot_sum = {1'b0, m_rdata[RECW-1 -: TW]} + {1'b0, tn_mod[tn_q]};
  assign slot     = (slot_sum >= (TW+1)'(TokenSlots)) ?
                    TW'(slot_sum - (TW+1)'(TokenSlots)) : TW'(slot_sum);
  assign p_next   = ring_inc(p_q);
  assign run_end  = (run_q == NW'(CopyLen - 1));
  assign free_now = (held_q < MCW'(MsgSlots) && tused_q < TCW'(TokenSlots)) ?
                    7'(RCW'(RingBytes) - rused_q) : 7'd0;

  // one received character
  always_comb begin
    rcv_n    = rcv_q;
    acc_n    = 1'b0;
    done_n   = 1'b0;
    commit_n = 1'b0;
    rb_n     = 1'b0;
    rwi_n    = rwi_q;
    rused_n  = rused_q;
    twi_n    = twi_q;
    tused_n  = tused_q;
    cur_n    = cur_q;
    wi_n     = wi_q;
    held_n   = held_q;
    recf_n   = recf_q;
    recc_n   = recc_q;
    recb_n   = recb_q;
    bwe_n    = 1'b0;
    bwdata_n = 8'd0;
    twe_n    = 1'b0;
    twaddr_n = twi_q;
    twdata_n = rwi_q;
    if (!rcv_q) begin
      if (chr_q == start_q) begin
        cur_n  = '0;
        recf_n = twi_q;
        recc_n = '0;
        recb_n = '0;
        if (tused_q < TCW'(TokenSlots)) begin
          twe_n   = 1'b1;
          twi_n   = tok_inc(twi_q);
          cur_n   = TCW'(1);
          tused_n = tused_q + TCW'(1);
          rcv_n   = 1'b1;
          acc_n   = 1'b1;
        end
      end
    end else if (chr_q == delim_q) begin
      if (rused_q < RCW'(RingBytes)) begin
        bwe_n   = 1'b1;
        rwi_n   = ring_inc(rwi_q);
        rused_n = rused_q + RCW'(1);
        recb_n  = recb_q + RCW'(1);
        if (tused_q < TCW'(TokenSlots)) begin
          twe_n    = 1'b1;
          twdata_n = rwi_n;
          twi_n    = tok_inc(twi_q);
          cur_n    = cur_q + TCW'(1);
          tused_n  = tused_q + TCW'(1);
          acc_n    = 1'b1;
        end else begin
          rb_n = 1'b1;
        end
      end else begin
        rb_n = 1'b1;
      end
    end else if (chr_q == stop_q) begin
      if (held_q >= MCW'(MsgSlots) || !rdy_q || rused_q >= RCW'(RingBytes)) begin
        rb_n = 1'b1;
      end else begin
        bwe_n    = 1'b1;
        rwi_n    = ring_inc(rwi_q);
        rused_n  = rused_q + RCW'(1);
        recb_n   = recb_q + RCW'(1);
        held_n   = held_q + MCW'(1);
        recc_n   = cur_q;
        commit_n = 1'b1;
        wi_n     = msg_inc(wi_q);
        cur_n    = '0;
        rcv_n    = 1'b0;
        done_n   = 1'b1;
        acc_n    = 1'b1;
      end
    end else if (chr_q == start_q) begin
      // restart: drop the open message, reopen its first token
      cur_n   = '0;
      twi_n   = recf_q;
      tused_n = bk_tused_q;
      rwi_n   = bk_rwi_q;
      rused_n = bk_rused_q;
      rcv_n   = 1'b0;
      recb_n  = '0;
      if (bk_tused_q < TCW'(TokenSlots)) begin
        twe_n    = 1'b1;
        twaddr_n = recf_q;
        twdata_n = bk_rwi_q;
        twi_n    = tok_inc(recf_q);
        cur_n    = TCW'(1);
        tused_n  = bk_tused_q + TCW'(1);
        rcv_n    = 1'b1;
      end
    end else begin
      if (rused_q < RCW'(RingBytes)) begin
        bwe_n    = 1'b1;
        bwdata_n = chr_q;
        rwi_n    = ring_inc(rwi_q);
        rused_n  = rused_q + RCW'(1);
        recb_n   = recb_q + RCW'(1);
        acc_n    = 1'b1;
      end else begin
        rb_n = 1'b1;
      end
    end
    if (rb_n) begin
      twi_n   = recf_q;
      tused_n = bk_tused_q;
      rwi_n   = bk_rwi_q;
      rused_n = bk_rused_q;
      rcv_n   = 1'b0;
    end
  end

  // RAM port control
  always_comb begin
    b_we    = (state_q == S_EXEC) && (op_q == OP_RX_CHAR) && bwe_n;
    b_waddr = rwi_q;
    b_wdata = bwdata_n;
    b_raddr = (state_q == S_T2) ? t_rdata : p_next;
    t_we    = (state_q == S_EXEC) && (op_q == OP_RX_CHAR) && twe_n;
    t_waddr = twaddr_n;
    t_wdata = twdata_n;
    t_raddr = slot;
    m_raddr = (state_q == S_FILL) ? wi_q : ri_q;
    if (state_q == S_CLR) begin
      m_we    = 1'b1;
      m_waddr = ri_q;
      m_wdata = {m_rdata[RECW-1 -: TW], {TCW{1'b0}}, rd_bytes};
    end else begin
      m_we    = (state_q == S_EXEC) && (op_q == OP_RX_CHAR);
      m_waddr = wi_q;
      m_wdata = {recf_n, recc_n, recb_n};
    end
  end

  ftmq_ram #(.Width(8), .Depth(RingBytes)) u_byte_ring (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  ftmq_ram #(.Width(RW), .Depth(TokenSlots)) u_tok_ring (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ftmq_ram #(.Width(RECW), .Depth(MsgSlots)) u_msg_tab (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      start_q    <= StartCharRst;
      delim_q    <= DelimCharRst;
      stop_q     <= StopCharRst;
      rcv_q      <= 1'b0;
      rwi_q      <= '0;
      rused_q    <= '0;
      twi_q      <= '0;
      tused_q    <= '0;
      cur_q      <= '0;
      wi_q       <= '0;
      ri_q       <= '0;
      held_q     <= '0;
      bk_tused_q <= '0;
      bk_rwi_q   <= '0;
      bk_rused_q <= '0;
      recf_q     <= '0;
      recc_q     <= '0;
      recb_q     <= '0;
      ovalid_q   <= 1'b0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      last_q     <= 1'b0;
      run_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_START: start_q <= cfg_data_i;
          CFG_DELIM: delim_q <= cfg_data_i;
          CFG_STOP:  stop_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= op_i;
            chr_q   <= data_char_i;
            tn_q    <= token_number_i;
            rdy_q   <= consumer_ready_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc_q  <= 1'b0;
          done_q <= 1'b0;
          unique case (op_e'(op_q))
            OP_RX_CHAR: begin
              if (!rcv_q && chr_q == start_q) begin
                bk_tused_q <= tused_q;
                bk_rwi_q   <= rwi_q;
                bk_rused_q <= rused_q;
              end
              rcv_q   <= rcv_n;
              rwi_q   <= rwi_n;
              rused_q <= rused_n;
              twi_q   <= twi_n;
              tused_q <= tused_n;
              cur_q   <= cur_n;
              wi_q    <= wi_n;
              held_q  <= held_n;
              recf_q  <= recf_n;
              recc_q  <= recc_n;
              recb_q  <= recb_n;
              acc_q   <= acc_n;
              done_q  <= done_n;
              state_q <= commit_n ? S_FILL : S_REC;
            end
            OP_RELEASE:  state_q <= S_REL;
            OP_READ_TOK: state_q <= S_T1;
            default:     state_q <= S_CLR;
          endcase
        end
        S_REL: begin
          if (held_q != '0) begin
            tused_q <= (tused_q > rd_cnt) ? tused_q - rd_cnt : '0;
            rused_q <= (rused_q > rd_bytes) ? rused_q - rd_bytes : '0;
            ri_q    <= msg_inc(ri_q);
            held_q  <= held_q - MCW'(1);
          end
          state_q <= S_REC;
        end
        S_CLR: begin
          if (ri_q == wi_q) begin
            recc_q <= '0;
          end
          state_q <= S_REC;
        end
        S_T1: begin
          oldest_q <= rd_cnt;
          state_q  <= S_T2;
        end
        S_T2: begin
          p_q     <= t_rdata;
          run_q   <= '0;
          state_q <= S_B;
        end
        S_B: begin
          ovalid_q <= 1'b1;
          cnt_q    <= 4'(held_q);
          old_q    <= 6'(oldest_q);
          free_q   <= free_now;
          byte_q   <= run_end ? 8'd0 : b_rdata;
          last_q   <= run_end || (b_rdata == 8'd0);
          state_q  <= S_DRAIN;
        end
        S_FILL: state_q <= S_FILL2;
        S_FILL2: begin
          recf_q  <= m_rdata[RECW-1 -: TW];
          recc_q  <= rd_cnt;
          recb_q  <= rd_bytes;
          state_q <= S_OUT;
        end
        S_REC: state_q <= S_OUT;
        S_OUT: begin
          ovalid_q <= 1'b1;
          cnt_q    <= 4'(held_q);
          old_q    <= 6'(rd_cnt);
          free_q   <= free_now;
          byte_q   <= 8'd0;
          last_q   <= 1'b1;
          state_q  <= S_DRAIN;
        end
        S_DRAIN: begin
          if (out_take) begin
            ovalid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              // next byte read issued at p_next this cycle
              p_q     <= p_next;
              run_q   <= run_q + NW'(1);
              state_q <= S_B;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o          = ovalid_q;
  assign accepted_o           = acc_q;
  assign msg_complete_o       = done_q;
  assign msg_count_o          = cnt_q;
  assign oldest_token_count_o = old_q;
  assign free_bytes_o         = free_q;
  assign token_byte_o         = byte_q;
  assign last_o               = last_q;

  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= MCW'(MsgSlots))
    else $error("message count above table size");

  a_ring_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rused_q <= RCW'(RingBytes) && tused_q <= TCW'(TokenSlots))
    else $error("ring usage above capacity");

  a_idle_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  a_done_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_complete_o |-> accepted_o && last_o)
    else $error("commit flagged without acceptance");

endmodule
